// ----- design/bba_pkg.sv -----
// Shared types, codes and helpers for the buddy block allocator.
// No dependencies; imported by design/buddy_block_allocator.sv.
`default_nettype none

package bba_pkg;

	// Node occupancy mark kept for every tree node
	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_PARTIAL = 2'd1,
		MARK_FULL    = 2'd2
	} mark_t;

	// One tree node as held in the node memory
	typedef struct packed {
		logic  split;
		mark_t mark;
	} node_t;

	// Command carried on the input tuser
	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	// Result status carried on the output tuser
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOSPACE  = 2'd1,
		STAT_TOOBIG   = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROUND,
		ST_ALOOK,
		ST_AEVAL,
		ST_ABACK,
		ST_ASPLIT,
		ST_FLOOK,
		ST_FEVAL,
		ST_FIXRD,
		ST_FIXWR,
		ST_FINISH
	} state_t;

	// Rebuild a split parent from its two children; merge when both are empty
	function automatic node_t fix_parent(input mark_t a, input mark_t b);
		node_t p;
		if (a == MARK_FULL && b == MARK_FULL) begin
			p.split = 1'b1;
			p.mark  = MARK_FULL;
		end else if (a != MARK_EMPTY || b != MARK_EMPTY) begin
			p.split = 1'b1;
			p.mark  = MARK_PARTIAL;
		end else begin
			p.split = 1'b0;
			p.mark  = MARK_EMPTY;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ----- design/buddy_block_allocator.sv -----
// Binary buddy block allocator: node memory, sequencer and result register.
// Depends on bba_pkg (design/bba_pkg.sv).
`default_nettype none

// Buddy allocator over a pool of 2^(LEVELS+MIN_BLOCK_LOG) bytes, tracked as a
// heap-indexed tree of node marks in a single one-port-write, one-port-read
// node memory. After reset the block sweeps the memory before it first raises
// s_axis_tready. Each word is handled alone: ready is high only while the
// sequencer is idle, but a finished result may still wait on the master side
// while the next word is taken. Every tree node visited takes a memory read,
// then an evaluate step, as the node memory has a single read port. An
// allocate rounds the request up by doubling (not for a request below the
// minimum block), inspects nodes, backtracks, splits down to the target level
// and walks back to the root. A free descends to the block and walks back to
// the root; a miss ends at the depth where it is found. The last step
// stretches while the previous result still waits on the master side.
module buddy_block_allocator
	import bba_pkg::*;
#(
	parameter int LEVELS        = 8,
	parameter int MIN_BLOCK_LOG = 12
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [55:0] s_axis_tdata,   // req_size [31:0], free_offset [51:32], zeros
	input  wire  [0:0]  s_axis_tuser,   // cmd [0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,   // block_offset [19:0], block_bytes [40:20],
	                                    // free_bytes [61:41], zeros
	output logic [1:0]  m_axis_tuser    // status [1:0]
);

	localparam int PL    = LEVELS + MIN_BLOCK_LOG;
	localparam int PW    = PL + 1;
	localparam int BW    = PL;
	localparam int NW    = LEVELS + 1;
	localparam int LW    = $clog2(LEVELS + 1);
	localparam int DEPTH = 2 ** NW;

	localparam logic [PW-1:0] POOL_B  = PW'(1) << PL;
	localparam logic [PW-1:0] MIN_B   = PW'(1) << MIN_BLOCK_LOG;
	localparam logic [32:0]   POOL_X  = 33'd1 << PL;
	localparam logic [31:0]   MIN_X   = 32'd1 << MIN_BLOCK_LOG;
	localparam logic [NW-1:0] ROOT    = NW'(1);
	localparam logic [LW-1:0] LEAF_LV = LW'(LEVELS);

	state_t state_q, state_d;
	logic [NW-1:0] n_q, n_d;
	logic [LW-1:0] lv_q, lv_d, tl_q, tl_d;
	logic [PW-1:0] size_q, size_d, p_q, p_d, rbytes_q, rbytes_d;
	logic [PW-1:0] fc_q, fc_d, fc_new;
	logic [BW-1:0] base_q, base_d, roff_q, roff_d;
	logic [31:0]   want_q, want_d;
	logic [19:0]   tgt_q, tgt_d;
	logic          free_op_q, free_op_d;
	mark_t         cur_q, cur_d;
	status_t       rs_q, rs_d;
	logic          mv_q, mv_d;
	status_t       mst_q, mst_d;
	logic [19:0]   moff_q, moff_d;
	logic [20:0]   mbytes_q, mbytes_d, mfree_q, mfree_d;

	node_t         mem [DEPTH];
	node_t         rdata_q, wdata, par;
	logic [NW-1:0] rd_addr, wr_addr;
	logic          we;

	// Request fields
	logic [31:0] in_req;
	logic [19:0] in_off;
	assign in_req = s_axis_tdata[31:0];
	assign in_off = s_axis_tdata[51:32];

	assign par    = fix_parent(cur_q, rdata_q.mark);
	assign fc_new = (rs_q != STAT_OK) ? fc_q :
	                free_op_q ? fc_q + rbytes_q : fc_q - rbytes_q;

	// Next state and next register values
	always_comb begin
		state_d   = state_q;
		n_d       = n_q;
		lv_d      = lv_q;
		tl_d      = tl_q;
		size_d    = size_q;
		base_d    = base_q;
		p_d       = p_q;
		want_d    = want_q;
		tgt_d     = tgt_q;
		free_op_d = free_op_q;
		cur_d     = cur_q;
		rs_d      = rs_q;
		roff_d    = roff_q;
		rbytes_d  = rbytes_q;
		fc_d      = fc_q;
		mv_d      = mv_q && !m_axis_tready;
		mst_d     = mst_q;
		moff_d    = moff_q;
		mbytes_d  = mbytes_q;
		mfree_d   = mfree_q;
		unique case (state_q)
			ST_CLEAR: begin
				n_d = n_q + NW'(1);
				if (n_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					free_op_d = (cmd_t'(s_axis_tuser[0]) == CMD_FREE);
					want_d    = in_req;
					tgt_d     = in_off;
					n_d       = ROOT;
					lv_d      = '0;
					tl_d      = LEAF_LV;
					size_d    = POOL_B;
					base_d    = '0;
					p_d       = MIN_B;
					rs_d      = STAT_OK;
					roff_d    = '0;
					rbytes_d  = '0;
					if (cmd_t'(s_axis_tuser[0]) == CMD_FREE) begin
						if ({13'd0, in_off} >= POOL_X) begin
							rs_d    = STAT_NOTFOUND;
							state_d = ST_FINISH;
						end else begin
							state_d = ST_FLOOK;
						end
					end else if (in_req < MIN_X) begin
						state_d = ST_ALOOK;
					end else if ({1'b0, in_req} > POOL_X) begin
						rs_d    = STAT_TOOBIG;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_ROUND;
					end
				end
			end
			ST_ROUND: begin
				// Double the block until it covers the request
				if (33'(p_q) < {1'b0, want_q}) begin
					p_d  = p_q << 1;
					tl_d = tl_q - LW'(1);
				end else begin
					state_d = ST_ALOOK;
				end
			end
			ST_ALOOK: state_d = ST_AEVAL;
			ST_AEVAL: begin
				priority if (rdata_q.mark == MARK_FULL) begin
					state_d = ST_ABACK;
				end else if (rdata_q.split && lv_q < LEAF_LV) begin
					n_d     = n_q << 1;
					lv_d    = lv_q + LW'(1);
					size_d  = size_q >> 1;
					state_d = ST_ALOOK;
				end else if (lv_q > tl_q) begin
					state_d = ST_ABACK;
				end else begin
					state_d = ST_ASPLIT;
				end
			end
			ST_ABACK: begin
				// Climb out of right children, then step to the right sibling
				priority if (n_q == ROOT) begin
					rs_d    = STAT_NOSPACE;
					state_d = ST_FINISH;
				end else if (n_q[0]) begin
					n_d    = n_q >> 1;
					lv_d   = lv_q - LW'(1);
					base_d = base_q & ~BW'(size_q);
					size_d = size_q << 1;
				end else begin
					n_d     = n_q | NW'(1);
					base_d  = base_q | BW'(size_q);
					state_d = ST_ALOOK;
				end
			end
			ST_ASPLIT: begin
				if (lv_q == tl_q) begin
					cur_d    = MARK_FULL;
					roff_d   = base_q;
					rbytes_d = p_q;
					state_d  = (n_q == ROOT) ? ST_FINISH : ST_FIXRD;
				end else begin
					n_d    = n_q << 1;
					lv_d   = lv_q + LW'(1);
					size_d = size_q >> 1;
				end
			end
			ST_FLOOK: state_d = ST_FEVAL;
			ST_FEVAL: begin
				priority if (rdata_q.split && lv_q < LEAF_LV) begin
					n_d     = {n_q[NW-2:0], ((PW'(tgt_q) & (size_q >> 1)) != '0)};
					lv_d    = lv_q + LW'(1);
					size_d  = size_q >> 1;
					state_d = ST_FLOOK;
				end else if (rdata_q.mark == MARK_FULL &&
				             (PW'(tgt_q) & (size_q - PW'(1))) == '0) begin
					cur_d    = MARK_EMPTY;
					roff_d   = BW'(tgt_q);
					rbytes_d = size_q;
					state_d  = (n_q == ROOT) ? ST_FINISH : ST_FIXRD;
				end else begin
					rs_d    = STAT_NOTFOUND;
					state_d = ST_FINISH;
				end
			end
			ST_FIXRD: state_d = ST_FIXWR;
			ST_FIXWR: begin
				cur_d   = par.mark;
				n_d     = n_q >> 1;
				state_d = ((n_q >> 1) == ROOT) ? ST_FINISH : ST_FIXRD;
			end
			ST_FINISH: begin
				// Hand the word over once the output register is free
				if (!mv_q || m_axis_tready) begin
					mv_d     = 1'b1;
					mst_d    = rs_q;
					moff_d   = 20'(roff_q);
					mbytes_d = 21'(rbytes_q);
					mfree_d  = 21'(fc_new);
					fc_d     = fc_new;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control and handshake outputs
	always_comb begin
		we            = 1'b0;
		wr_addr       = n_q;
		wdata         = '0;
		rd_addr       = (state_q == ST_FIXRD) ? (n_q ^ NW'(1)) : n_q;
		s_axis_tready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_ASPLIT: begin
				we = 1'b1;
				if (lv_q == tl_q) begin
					wdata.mark = MARK_FULL;
				end else begin
					wr_addr = (n_q << 1) | NW'(1);
				end
			end
			ST_FEVAL: begin
				we = !(rdata_q.split && lv_q < LEAF_LV) && rdata_q.mark == MARK_FULL &&
				     (PW'(tgt_q) & (size_q - PW'(1))) == '0;
			end
			ST_FIXWR: begin
				we      = 1'b1;
				wr_addr = n_q >> 1;
				wdata   = par;
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = mv_q;
	assign m_axis_tuser  = mst_q;
	assign m_axis_tdata  = {2'b00, mfree_q, mbytes_q, moff_q};

	// Node memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wdata;
		rdata_q <= mem[rd_addr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			n_q     <= '0;
			mv_q    <= 1'b0;
			fc_q    <= POOL_B;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			mv_q    <= mv_d;
			fc_q    <= fc_d;
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		lv_q      <= lv_d;
		tl_q      <= tl_d;
		size_q    <= size_d;
		base_q    <= base_d;
		p_q       <= p_d;
		want_q    <= want_d;
		tgt_q     <= tgt_d;
		free_op_q <= free_op_d;
		cur_q     <= cur_d;
		rs_q      <= rs_d;
		roff_q    <= roff_d;
		rbytes_q  <= rbytes_d;
		mst_q     <= mst_d;
		moff_q    <= moff_d;
		mbytes_q  <= mbytes_d;
		mfree_q   <= mfree_d;
	end

endmodule

`default_nettype wire

// ----- bench/bba_checker.sv -----
// Checker for the buddy block allocator: watches both streams, predicts results.
// Depends on bba_pkg (design/bba_pkg.sv); instantiated by bench/tb_top.sv.
`default_nettype none

module bba_checker
	import bba_pkg::*;
#(
	parameter int LEVELS        = 8,
	parameter int MIN_BLOCK_LOG = 12
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [55:0] s_axis_tdata,
	input  wire  [0:0]  s_axis_tuser,
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [63:0] m_axis_tdata,
	input  wire  [1:0]  m_axis_tuser,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_LOG = LEVELS + MIN_BLOCK_LOG;
	localparam longint POOL_BYTES = longint'(1) << POOL_LOG;
	localparam int SLOTS = 1 << (LEVELS + 1);

	typedef struct {
		status_t     status;
		logic [19:0] offset;
		logic [20:0] bytes;
		logic [20:0] remaining;
	} grant_t;

	mark_t  mark_q  [SLOTS];
	logic   split_q [SLOTS];
	longint pool_free;
	grant_t grants_due[$];

	// rebuild a split node from its children, merge when both are empty
	function automatic void rejoin(int n);
		mark_t a, b;
		a = mark_q[2*n];
		b = mark_q[2*n+1];
		if (a == MARK_FULL && b == MARK_FULL) mark_q[n] = MARK_FULL;
		else if (a != MARK_EMPTY || b != MARK_EMPTY) mark_q[n] = MARK_PARTIAL;
		else begin
			mark_q[n] = MARK_EMPTY;
			split_q[n] = 1'b0;
			split_q[2*n] = 1'b0;
			split_q[2*n+1] = 1'b0;
		end
	endfunction

	function automatic bit carve(int n, int lvl, longint base, longint want,
	                             inout longint off);
		longint nsize;
		bit got;
		nsize = POOL_BYTES >> lvl;
		if (mark_q[n] == MARK_FULL) return 0;
		if (split_q[n] && lvl < LEVELS) begin
			got = carve(2*n, lvl+1, base, want, off);
			if (!got) got = carve(2*n+1, lvl+1, base + nsize/2, want, off);
			rejoin(n);
			return got;
		end
		if (want > nsize) return 0;
		if (lvl < LEVELS && nsize/2 >= want) begin
			split_q[n] = 1'b1;
			mark_q[2*n] = MARK_EMPTY;
			mark_q[2*n+1] = MARK_EMPTY;
			split_q[2*n] = 1'b0;
			split_q[2*n+1] = 1'b0;
			got = carve(2*n, lvl+1, base, want, off);
			rejoin(n);
			return got;
		end
		mark_q[n] = MARK_FULL;
		off = base;
		return 1;
	endfunction

	function automatic longint release_at(int n, int lvl, longint base, longint target);
		longint nsize, got;
		nsize = POOL_BYTES >> lvl;
		if (split_q[n] && lvl < LEVELS) begin
			if (target >= base + nsize/2)
				got = release_at(2*n+1, lvl+1, base + nsize/2, target);
			else
				got = release_at(2*n, lvl+1, base, target);
			rejoin(n);
			return got;
		end
		if (mark_q[n] == MARK_FULL && target == base) begin
			mark_q[n] = MARK_EMPTY;
			return nsize;
		end
		return 0;
	endfunction

	function automatic grant_t serve(cmd_t cmd, logic [31:0] req, logic [19:0] where);
		grant_t g;
		longint want, p, off, got;
		g = '{STAT_OK, '0, '0, '0};
		if (cmd == CMD_ALLOC) begin
			want = longint'(req);
			if (want < (longint'(1) << MIN_BLOCK_LOG)) want = longint'(1) << MIN_BLOCK_LOG;
			if (want > POOL_BYTES) g.status = STAT_TOOBIG;
			else begin
				p = longint'(1) << MIN_BLOCK_LOG;
				while (p < want) p = p << 1;
				off = 0;
				if (carve(1, 0, 0, p, off)) begin
					g.offset = off[19:0];
					g.bytes = p[20:0];
					pool_free -= p;
				end else g.status = STAT_NOSPACE;
			end
		end else begin
			got = release_at(1, 0, 0, longint'(where));
			if (got != 0) begin
				g.offset = where;
				g.bytes = got[20:0];
				pool_free += got;
			end else g.status = STAT_NOTFOUND;
		end
		g.remaining = pool_free[20:0];
		return g;
	endfunction

	// predict on each input word, compare on each output word
	always @(posedge clk or negedge arst_n) begin
		grant_t e;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				mark_q[i] = MARK_EMPTY;
				split_q[i] = 1'b0;
			end
			pool_free = POOL_BYTES;
			grants_due.delete();
			mismatches = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				grants_due.push_back(serve(cmd_t'(s_axis_tuser[0]), s_axis_tdata[31:0],
				                           s_axis_tdata[51:32]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (grants_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
				end else begin
					e = grants_due.pop_front();
					if (m_axis_tuser !== e.status || m_axis_tdata[19:0] !== e.offset ||
					    m_axis_tdata[40:20] !== e.bytes ||
					    m_axis_tdata[61:41] !== e.remaining || m_axis_tdata[63:62] !== 2'b0) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: exp st %0d off %h bytes %0d free %0d,",
							          " got st %0d off %h bytes %0d free %0d"},
								e.status, e.offset, e.bytes, e.remaining, m_axis_tuser,
								m_axis_tdata[19:0], m_axis_tdata[40:20], m_axis_tdata[61:41]);
					end
				end
			end
		end
		pending = grants_due.size();
	end
endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Stimulus and verdict for the buddy block allocator bench.
// Depends on bba_pkg, buddy_block_allocator and bench/bba_checker.sv.
`default_nettype none

module tb_top;
	import bba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [55:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tready = 1'b0;
	wire         s_axis_tready, m_axis_tvalid;
	wire  [63:0] m_axis_tdata;
	wire  [1:0]  m_axis_tuser;
	int          mismatches, pending;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	buddy_block_allocator DUT (.*);
	bba_checker checker_i (.*);

	// send one word, hold until taken, then an optional gap of the given length
	task automatic send_word(cmd_t cmd, logic [31:0] req, logic [19:0] where, int gap);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0, where, req};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// receiver stall pattern: long open stretches, then choppy ones
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 40) == 0) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 63) < 32) ? 1'b1 :
				                 ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin
		int burst, g, k;
		logic [31:0] sz;
		logic [19:0] off;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: tiny, zero, extremes, exact pool, oversize, frees
		send_word(CMD_ALLOC, 32'd0, 20'hFFFFF, 0);
		send_word(CMD_ALLOC, 32'd1, 20'h0, 1);
		send_word(CMD_ALLOC, 32'h1000, 20'h0, 0);
		send_word(CMD_ALLOC, 32'h1001, 20'h0, 2);
		send_word(CMD_ALLOC, 32'hFFFFFFFF, 20'h0, 0);
		send_word(CMD_ALLOC, 32'h100001, 20'h0, 0);
		send_word(CMD_ALLOC, 32'h100000, 20'h0, 0);
		send_word(CMD_FREE, 32'hFFFFFFFF, 20'h0, 0);
		send_word(CMD_FREE, 32'h0, 20'h1000, 0);
		send_word(CMD_FREE, 32'h0, 20'h2000, 0);
		send_word(CMD_FREE, 32'h0, 20'hFFFFF, 0);
		send_word(CMD_FREE, 32'h0, 20'h0, 0);
		send_word(CMD_ALLOC, 32'h100000, 20'h0, 0);
		send_word(CMD_ALLOC, 32'h1000, 20'h0, 0);
		send_word(CMD_FREE, 32'h0, 20'h0, 0);
		send_word(CMD_FREE, 32'h0, 20'h0, 0);
		send_word(CMD_FREE, 32'h0, 20'h0, 0);
		// random: mostly sized allocs and frees at aligned offsets, some noise
		k = 0;
		while (k < 900) begin
			burst = $urandom_range(1, 12);
			g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			repeat (burst) begin
				case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					sz = $urandom_range(0, 1 << $urandom_range(0, 20));
					if ($urandom_range(0, 15) == 0) sz = $urandom;
					send_word(CMD_ALLOC, sz, 20'($urandom), 0);
				end
				4, 5, 6, 7: begin
					off = {8'($urandom_range(0, 255)), 12'h0};
					if ($urandom_range(0, 3) == 0) off = {5'($urandom_range(0, 31)), 15'h0};
					send_word(CMD_FREE, $urandom, off, 0);
				end
				8: send_word(CMD_FREE, $urandom, 20'($urandom), 0);
				default: send_word(CMD_ALLOC, $urandom, 20'($urandom), 0);
				endcase
				k++;
			end
			if (g > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (mismatches == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	// hard stop if the stream stalls
	initial begin
		#40ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

`default_nettype wire
